// File: design/rop2pb_pkg.sv
package rop2pb_pkg;

  // Field widths
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned COV_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROP_CODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT = 1'd1;

  // Destination formats
  localparam logic FMT_ARGB = 1'b0;
  localparam logic FMT_A8   = 1'b1;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [COV_W-1:0] COV_NONE     = 8'h00;
  localparam logic [COV_W-1:0] COV_FULL     = 8'hFF;

  // Binary raster operations
  typedef enum logic [3:0] {
    ROP_CLEAR       = 4'd0,
    ROP_COPY        = 4'd1,
    ROP_ANDINVERT   = 4'd2,
    ROP_COPYINVERT  = 4'd3,
    ROP_ANDREVERSE  = 4'd4,
    ROP_INVERT      = 4'd5,
    ROP_XOR         = 4'd6,
    ROP_NAND        = 4'd7,
    ROP_AND         = 4'd8,
    ROP_EQUIV       = 4'd9,
    ROP_NOOP        = 4'd10,
    ROP_ORINVERT    = 4'd11,
    ROP_ORREVERSE   = 4'd12,
    ROP_OR          = 4'd13,
    ROP_SET         = 4'd14,
    ROP_NONE        = 4'd15
  } rop_t;

  // One pixel request held in the input register
  typedef struct packed {
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
    logic [COV_W-1:0] cov;
    logic             span_end;
  } pix_req_t;

endpackage

// File: design/rop2pb_rop.sv
module rop2pb_rop (
  input  rop2pb_pkg::rop_t                code,
  input  logic [rop2pb_pkg::PIX_W-1:0]    src,
  input  logic [rop2pb_pkg::PIX_W-1:0]    dst,
  output logic [rop2pb_pkg::PIX_W-1:0]    res
);

  logic [rop2pb_pkg::PIX_W-1:0] raw;

  // Bitwise combine; clear, copy and noop keep their own alpha
  always_comb begin
    raw = '1;
    res = '0;
    case (code)
      rop2pb_pkg::ROP_CLEAR:      res = '0;
      rop2pb_pkg::ROP_COPY:       res = src;
      rop2pb_pkg::ROP_NOOP:       res = dst;
      default: begin
        case (code)
          rop2pb_pkg::ROP_ANDINVERT:  raw = ~src & dst;
          rop2pb_pkg::ROP_COPYINVERT: raw = ~src;
          rop2pb_pkg::ROP_ANDREVERSE: raw = src & ~dst;
          rop2pb_pkg::ROP_INVERT:     raw = ~dst;
          rop2pb_pkg::ROP_XOR:        raw = src ^ dst;
          rop2pb_pkg::ROP_NAND:       raw = ~src | ~dst;
          rop2pb_pkg::ROP_AND:        raw = src & dst;
          rop2pb_pkg::ROP_EQUIV:      raw = ~src ^ dst;
          rop2pb_pkg::ROP_ORINVERT:   raw = ~src | dst;
          rop2pb_pkg::ROP_ORREVERSE:  raw = src | ~dst;
          rop2pb_pkg::ROP_OR:         raw = src | dst;
          default:                    raw = '1;  // set and none
        endcase
        res = raw | rop2pb_pkg::ALPHA_OPAQUE;
      end
    endcase
  end

endmodule

// File: design/rop2pb_blend.sv
module rop2pb_blend (
  input  logic [rop2pb_pkg::PIX_W-1:0] res,
  input  logic [rop2pb_pkg::PIX_W-1:0] dst,
  input  logic [rop2pb_pkg::COV_W-1:0] cov,
  output logic [rop2pb_pkg::PIX_W-1:0] blended
);

  localparam int unsigned NUM_CH = rop2pb_pkg::PIX_W / rop2pb_pkg::CH_W;
  localparam int unsigned CH_W   = rop2pb_pkg::CH_W;

  logic [rop2pb_pkg::COV_W:0] scale;
  logic [rop2pb_pkg::PIX_W-1:0] lerp;

  // cov + 1, so full coverage maps to 256
  assign scale = {1'b0, cov} + {{rop2pb_pkg::COV_W{1'b0}}, 1'b1};

  // Per channel: d + floor((r - d) * scale / 256)
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic signed [CH_W:0]                        diff;
    logic signed [CH_W+rop2pb_pkg::COV_W+2:0]    prod;
    logic signed [CH_W+rop2pb_pkg::COV_W+2:0]    delta;

    assign diff  = $signed({1'b0, res[ch*CH_W +: CH_W]}) -
                   $signed({1'b0, dst[ch*CH_W +: CH_W]});
    assign prod  = diff * $signed({1'b0, scale});
    assign delta = prod >>> CH_W;
    assign lerp[ch*CH_W +: CH_W] = dst[ch*CH_W +: CH_W] + delta[CH_W-1:0];
  end

  // Full coverage takes the operation result as is
  assign blended = (cov == rop2pb_pkg::COV_FULL) ? res : lerp;

endmodule

// File: design/rop2_pixel_blender_top.sv
// Path: an accepted request goes through the input register, then the result
//   register, to out_valid, and is held in place while out_stall holds.
// Throughput: one pixel per cycle while out_stall is low; all work is one
//   combinational pass between the input and result registers.
// Reset (synchronous, rst_n low): both pipeline stages empty, rop_code = copy,
//   dest_format = 32-bit ARGB.
module rop2_pixel_blender_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [rop2pb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rop2pb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // pixel requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rop2pb_pkg::PIX_W-1:0]         in_source_pixel,
  input  logic [rop2pb_pkg::PIX_W-1:0]         in_dest_pixel,
  input  logic [rop2pb_pkg::COV_W-1:0]         in_coverage,
  input  logic                                 in_span_end,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rop2pb_pkg::PIX_W-1:0]         out_new_dest_pixel,
  output logic                                 out_span_end_out
);

  rop2pb_pkg::rop_t             rop_code_r, rop_code_nxt;
  logic                         dest_format_r, dest_format_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  rop2pb_pkg::pix_req_t         s1_req_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [rop2pb_pkg::PIX_W-1:0] out_pix_r;
  logic                         out_end_r;

  logic                         in_accept;
  logic                         out_en;
  logic                         s1_adv;
  logic [rop2pb_pkg::CH_W-1:0]  dst_alpha;
  logic [rop2pb_pkg::PIX_W-1:0] dst_vec;
  logic [rop2pb_pkg::PIX_W-1:0] rop_res;
  logic [rop2pb_pkg::PIX_W-1:0] blend_res;
  logic                         keep_dst;
  logic [rop2pb_pkg::PIX_W-1:0] pix_nxt;

  // Handshake: result register frees when empty or taken
  assign out_en    = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_en;
  assign in_stall  = s1_valid_r && !out_en;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes
  always_comb begin
    rop_code_nxt    = rop_code_r;
    dest_format_nxt = dest_format_r;
    if (cfg_we) begin
      case (cfg_index)
        rop2pb_pkg::CFG_ROP_CODE:    rop_code_nxt = rop2pb_pkg::rop_t'(cfg_wdata[3:0]);
        rop2pb_pkg::CFG_DEST_FORMAT: dest_format_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage valid bits
  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_en ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rop_code_r    <= rop2pb_pkg::ROP_COPY;
      dest_format_r <= rop2pb_pkg::FMT_ARGB;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rop_code_r    <= rop_code_nxt;
      dest_format_r <= dest_format_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r.src      <= in_source_pixel;
      s1_req_r.dst      <= in_dest_pixel;
      s1_req_r.cov      <= in_coverage;
      s1_req_r.span_end <= in_span_end;
    end
  end

  // A8 destination: alpha moves to the top byte
  assign dst_alpha = s1_req_r.dst[rop2pb_pkg::CH_W-1:0];
  assign dst_vec   = (dest_format_r == rop2pb_pkg::FMT_A8) ?
                     {dst_alpha, {(rop2pb_pkg::PIX_W-rop2pb_pkg::CH_W){1'b0}}} :
                     s1_req_r.dst;

  rop2pb_rop u_rop (
    .code (rop_code_r),
    .src  (s1_req_r.src),
    .dst  (dst_vec),
    .res  (rop_res)
  );

  rop2pb_blend u_blend (
    .res     (rop_res),
    .dst     (dst_vec),
    .cov     (s1_req_r.cov),
    .blended (blend_res)
  );

  // Result select: the none code or zero coverage keeps the destination
  assign keep_dst = (rop_code_r == rop2pb_pkg::ROP_NONE) ||
                    (s1_req_r.cov == rop2pb_pkg::COV_NONE);

  always_comb begin
    if (dest_format_r == rop2pb_pkg::FMT_A8) begin
      pix_nxt = {{(rop2pb_pkg::PIX_W-rop2pb_pkg::CH_W){1'b0}},
                 keep_dst ? dst_alpha
                          : blend_res[rop2pb_pkg::PIX_W-1 -: rop2pb_pkg::CH_W]};
    end else begin
      pix_nxt = keep_dst ? s1_req_r.dst : blend_res;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r <= pix_nxt;
      out_end_r <= s1_req_r.span_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_dest_pixel = out_pix_r;
  assign out_span_end_out   = out_end_r;

endmodule

// File: design/rop2pb_checker.sv
module rop2pb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [rop2pb_pkg::PIX_W-1:0]         in_source_pixel,
  input logic [rop2pb_pkg::PIX_W-1:0]         in_dest_pixel,
  input logic [rop2pb_pkg::COV_W-1:0]         in_coverage,
  input logic                                 in_span_end,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [rop2pb_pkg::PIX_W-1:0]         out_new_dest_pixel,
  input logic                                 out_span_end_out
);

  // A stalled request stays offered with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_source_pixel) &&
      $stable(in_dest_pixel) && $stable(in_coverage) && $stable(in_span_end))
    else $error("request changed while stalled");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_new_dest_pixel) && $stable(out_span_end_out))
    else $error("result payload changed while stalled");

  // Input backs up only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rop2_pixel_blender_top rop2pb_checker u_rop2pb_checker (.*);
